// ----- src/hhsa_pkg.sv -----
// ============================================================================
// hhsa_pkg - shared types and constants for the helix hit sine angle core
// Field widths, status codes and the control word that rides with each beat.
// ============================================================================
package hhsa_pkg;

    // Fixed widths of the beat fields
    localparam int T_W      = 18;
    localparam int C_W      = 24;
    localparam int OUT_W    = 18;
    localparam int STAT_W   = 2;

    // Split point of t*t ahead of the c*t*t partial products
    localparam int TT_SPLIT = 18;

    typedef enum logic [STAT_W-1:0] {
        STAT_NORMAL     = 2'd0,
        STAT_NO_SOL_POS = 2'd1,
        STAT_NO_SOL_NEG = 2'd2,
        STAT_CLAMPED    = 2'd3
    } hhsa_stat_t;

    // Control word traveling alongside the datapath
    typedef struct packed {
        logic       valid;
        logic       rneg;
        hhsa_stat_t stat;
    } hhsa_ctl_t;

endpackage

// ----- src/helix_hit_sine_angle_core.sv -----
// ============================================================================
// helix_hit_sine_angle_core - sine of the momentum-to-hit angle of a helix
// Throughput: one beat per cycle, once busy has dropped after reset.
// The depth is set by the FRAC_BITS+1 restoring-division stages after five
// stages of multiply, add and range check, followed by the output stage.
// Reset (rst_n, asynchronous) drops every valid bit and holds busy high for
// the first cycle after release; the receiver cannot stall the output.
// ============================================================================
module helix_hit_sine_angle_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [hhsa_pkg::T_W-1:0]       impact_param,
    input  logic signed [hhsa_pkg::C_W-1:0]       curvature,
    output logic                                  done,
    output logic signed [hhsa_pkg::OUT_W-1:0]     sine_angle,
    output logic [hhsa_pkg::STAT_W-1:0]           status
);

    // ------------------------------------------------------------------
    // Widths, all derived from FRAC_BITS and the fixed field widths
    // ------------------------------------------------------------------
    localparam int F      = FRAC_BITS;
    localparam int T_W    = hhsa_pkg::T_W;
    localparam int C_W    = hhsa_pkg::C_W;
    localparam int OUT_W  = hhsa_pkg::OUT_W;
    localparam int SPLIT  = hhsa_pkg::TT_SPLIT;
    localparam int ST_W   = ((F + 2 > T_W) ? F + 2 : T_W) + 1;   // one +/- t
    localparam int PC_W   = C_W + ST_W;                          // c*(one +/- t)
    localparam int CMPC_W = (PC_W > 2 * F + 3) ? PC_W : 2 * F + 3;
    localparam int TT_W   = 2 * T_W;                             // t*t
    localparam int TC_W   = T_W + C_W;                           // t*c
    localparam int CTP_W  = C_W + SPLIT + 1;                     // c*t*t partials
    localparam int A_W    = C_W + 2;                             // 2t - c
    localparam int DEN_W  = ((2 * F + 2 > TC_W) ? 2 * F + 2 : TC_W) + 2;
    localparam int NUM_W  = ((2 * F + A_W > CTP_W + SPLIT + 1) ?
                             2 * F + A_W : CTP_W + SPLIT + 1) + 2;
    localparam int DS_W   = DEN_W + F + 1;                       // den*(one+1)
    localparam int OV_W   = ((NUM_W > DS_W) ? NUM_W : DS_W);
    localparam int RES_W  = F + 2;
    localparam int LAT    = F + 7;

    localparam logic signed [ST_W-1:0]   ONE_ST = ST_W'(1) << F;
    localparam logic signed [CMPC_W-1:0] TWO_SS = CMPC_W'(1) << (2 * F + 1);
    localparam logic signed [CMPC_W-1:0] NEG_TWO_SS = -TWO_SS;
    localparam logic signed [DEN_W-1:0]  SS_DEN = DEN_W'(1) << (2 * F);
    localparam logic signed [RES_W-1:0]  ONE_RES = RES_W'(1) << F;
    localparam logic [RES_W+OUT_W-1:0]   NEG_ONE_X = -((RES_W + OUT_W)'(1) << F);
    localparam logic [OUT_W-1:0]         NEG_ONE_OUT = NEG_ONE_X[OUT_W-1:0];

    // ------------------------------------------------------------------
    // Handshake: busy only in the first cycle out of reset
    // ------------------------------------------------------------------
    logic busy_reg;
    logic accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    assign busy   = busy_reg;
    assign accept = start && !busy_reg;

    // ------------------------------------------------------------------
    // Stage A: all products of the raw inputs, one multiplier deep
    // ------------------------------------------------------------------
    logic signed [ST_W-1:0]  t_st;
    logic signed [ST_W-1:0]  spt;
    logic signed [ST_W-1:0]  smt;

    logic                    va_reg;
    logic                    t_gt_reg;     // t > -one
    logic                    t_lt_reg;     // t < one
    logic signed [PC_W-1:0]  cpt_reg;      // c*(one+t)
    logic signed [PC_W-1:0]  cmt_reg;      // c*(one-t)
    logic signed [TT_W-1:0]  tt_reg;       // t*t, never negative
    logic signed [TC_W-1:0]  tc_reg;       // t*c
    logic signed [A_W-1:0]   a_a_reg;      // 2t - c
    logic signed [C_W-1:0]   c_a_reg;

    assign t_st = ST_W'(impact_param);
    assign spt  = ONE_ST + t_st;
    assign smt  = ONE_ST - t_st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else
        begin
            va_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        t_gt_reg <= (t_st > -ONE_ST);
        t_lt_reg <= (t_st < ONE_ST);
        cpt_reg  <= PC_W'(curvature) * PC_W'(spt);
        cmt_reg  <= PC_W'(curvature) * PC_W'(smt);
        tt_reg   <= TT_W'(impact_param) * TT_W'(impact_param);
        tc_reg   <= TC_W'(impact_param) * TC_W'(curvature);
        a_a_reg  <= (A_W'(impact_param) <<< 1) - A_W'(curvature);
        c_a_reg  <= curvature;
    end

    // ------------------------------------------------------------------
    // Stage B: no-solution checks, c*t*t partial products, denominator
    // ------------------------------------------------------------------
    hhsa_pkg::hhsa_ctl_t      ctl_b_next;
    hhsa_pkg::hhsa_ctl_t      ctl_b_reg;
    logic signed [CTP_W-1:0]  ctt_lo_reg;
    logic signed [CTP_W-1:0]  ctt_hi_reg;
    logic signed [DEN_W-1:0]  den_b_reg;
    logic signed [A_W-1:0]    a_b_reg;

    always_comb
    begin
        ctl_b_next.valid = va_reg;
        ctl_b_next.rneg  = 1'b0;
        // the positive-curvature case wins when both apply
        priority if (t_gt_reg && (CMPC_W'(cpt_reg) >= TWO_SS))
        begin
            ctl_b_next.stat = hhsa_pkg::STAT_NO_SOL_POS;
        end
        else if (t_lt_reg && (CMPC_W'(cmt_reg) <= NEG_TWO_SS))
        begin
            ctl_b_next.stat = hhsa_pkg::STAT_NO_SOL_NEG;
        end
        else
        begin
            ctl_b_next.stat = hhsa_pkg::STAT_NORMAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_b_reg.valid <= 1'b0;
        end
        else
        begin
            ctl_b_reg <= ctl_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctt_lo_reg <= CTP_W'(c_a_reg) * CTP_W'(signed'({1'b0, tt_reg[SPLIT-1:0]}));
        ctt_hi_reg <= CTP_W'(c_a_reg) * CTP_W'(signed'({1'b0, tt_reg[TT_W-1:SPLIT]}));
        den_b_reg  <= (SS_DEN - DEN_W'(tc_reg)) <<< 1;
        a_b_reg    <= a_a_reg;
    end

    // ------------------------------------------------------------------
    // Stage C: numerator one^2*(2t-c) - c*t*t, divisor magnitude
    // ------------------------------------------------------------------
    hhsa_pkg::hhsa_ctl_t      ctl_c_reg;
    logic signed [NUM_W-1:0]  num_c_reg;
    logic [DEN_W-1:0]         dmag_c_reg;
    logic                     dneg_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_c_reg.valid <= 1'b0;
        end
        else
        begin
            ctl_c_reg <= ctl_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        num_c_reg  <= (NUM_W'(a_b_reg) <<< (2 * F))
                      - ((NUM_W'(ctt_hi_reg) <<< SPLIT) + NUM_W'(ctt_lo_reg));
        dmag_c_reg <= den_b_reg[DEN_W-1] ? DEN_W'(-den_b_reg) : DEN_W'(den_b_reg);
        dneg_c_reg <= den_b_reg[DEN_W-1];
    end

    // ------------------------------------------------------------------
    // Stage D: numerator magnitude, result sign, range bound den*(one+1)
    // ------------------------------------------------------------------
    hhsa_pkg::hhsa_ctl_t   ctl_d_next;
    hhsa_pkg::hhsa_ctl_t   ctl_d_reg;
    logic [NUM_W-1:0]      nm_d_reg;
    logic [DEN_W-1:0]      d_d_reg;
    logic [DS_W-1:0]       dsc_d_reg;

    always_comb
    begin
        ctl_d_next      = ctl_c_reg;
        ctl_d_next.rneg = num_c_reg[NUM_W-1] ^ dneg_c_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_d_reg.valid <= 1'b0;
        end
        else
        begin
            ctl_d_reg <= ctl_d_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nm_d_reg  <= num_c_reg[NUM_W-1] ? NUM_W'(-num_c_reg) : NUM_W'(num_c_reg);
        d_d_reg   <= dmag_c_reg;
        dsc_d_reg <= (DS_W'(dmag_c_reg) << F) + DS_W'(dmag_c_reg);
    end

    // ------------------------------------------------------------------
    // Stage E: clamp check; a quotient above one (or a zero divisor)
    // never reaches the divider as a normal beat
    // ------------------------------------------------------------------
    hhsa_pkg::hhsa_ctl_t   ctl_e_next;
    hhsa_pkg::hhsa_ctl_t   ctl_e_reg;
    logic [NUM_W-1:0]      nm_e_reg;
    logic [DEN_W-1:0]      d_e_reg;
    logic                  over;

    assign over = (OV_W'(nm_d_reg) >= OV_W'(dsc_d_reg));

    always_comb
    begin
        ctl_e_next = ctl_d_reg;
        if ((ctl_d_reg.stat == hhsa_pkg::STAT_NORMAL) && over)
        begin
            ctl_e_next.stat = hhsa_pkg::STAT_CLAMPED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_e_reg.valid <= 1'b0;
        end
        else
        begin
            ctl_e_reg <= ctl_e_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nm_e_reg <= nm_d_reg;
        d_e_reg  <= d_d_reg;
    end

    // ------------------------------------------------------------------
    // Division: FRAC_BITS+1 stages, one quotient bit each
    // ------------------------------------------------------------------
    hhsa_pkg::hhsa_ctl_t   ctl_q;
    logic [F:0]            quo;

    hhsa_div #(
        .FRAC_BITS (F),
        .NUM_W     (NUM_W),
        .DEN_W     (DEN_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl_e_reg),
        .num_in  (nm_e_reg),
        .den_in  (d_e_reg),
        .ctl_out (ctl_q),
        .quo_out (quo)
    );

    // ------------------------------------------------------------------
    // Output stage: apply sign or substitute the fixed answers, then
    // present the beat for one cycle with done
    // ------------------------------------------------------------------
    logic signed [RES_W-1:0]       q_s;
    logic signed [RES_W-1:0]       res;
    logic signed [RES_W+OUT_W-1:0] res_x;
    logic                          done_reg;
    logic [OUT_W-1:0]              sine_reg;
    logic [hhsa_pkg::STAT_W-1:0]   status_reg;

    assign q_s = signed'({1'b0, quo});

    always_comb
    begin
        unique case (ctl_q.stat)
            hhsa_pkg::STAT_NORMAL:     res = ctl_q.rneg ? -q_s : q_s;
            hhsa_pkg::STAT_NO_SOL_POS: res = -ONE_RES;
            hhsa_pkg::STAT_NO_SOL_NEG: res = ONE_RES;
            hhsa_pkg::STAT_CLAMPED:    res = ctl_q.rneg ? -ONE_RES : ONE_RES;
            default:                   res = ONE_RES;
        endcase
    end

    // sign-extend, then keep the low field bits (drops the top for wide fractions)
    assign res_x = {{OUT_W{res[RES_W-1]}}, res};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_q.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        sine_reg   <= res_x[OUT_W-1:0];
        status_reg <= ctl_q.stat;
    end

    assign done       = done_reg;
    assign sine_angle = signed'(sine_reg);
    assign status     = status_reg;

`ifndef SYNTH
    // every accepted beat comes out as a done pulse
    a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("core: accepted beat did not come out on time");

    // no result appears without a matching accepted beat
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("core: result without a matching beat");

    // the positive-curvature no-solution answer is minus one
    a_pos_is_neg_one: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == hhsa_pkg::STAT_NO_SOL_POS) |-> (sine_angle == NEG_ONE_OUT))
        else $error("core: no-solution result is not minus one");
`endif

endmodule

// ----- src/hhsa_div.sv -----
// ============================================================================
// hhsa_div - pipelined restoring divider
// One quotient bit per stage, most significant first; FRAC_BITS+1 stages.
// ============================================================================
module hhsa_div #(
    parameter int FRAC_BITS = 16,
    parameter int NUM_W     = 62,
    parameter int DEN_W     = 44
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hhsa_pkg::hhsa_ctl_t  ctl_in,
    input  logic [NUM_W-1:0]     num_in,
    input  logic [DEN_W-1:0]     den_in,
    output hhsa_pkg::hhsa_ctl_t  ctl_out,
    output logic [FRAC_BITS:0]   quo_out
);

    localparam int F     = FRAC_BITS;
    localparam int CMP_W = ((NUM_W > DEN_W + F) ? NUM_W : DEN_W + F) + 1;
    localparam logic [F:0] ONE_Q = {1'b1, {F{1'b0}}};

    hhsa_pkg::hhsa_ctl_t ctl_reg [0:F];
    logic [NUM_W-1:0]    r_reg   [0:F];
    logic [DEN_W-1:0]    d_reg   [0:F];
    logic [F:0]          q_reg   [0:F];

    for (genvar k = 0; k <= F; k++) begin : g_step
        localparam int SH = F - k;

        hhsa_pkg::hhsa_ctl_t c_in;
        logic [NUM_W-1:0]    r_in;
        logic [DEN_W-1:0]    d_in;
        logic [F:0]          q_in;
        logic [CMP_W-1:0]    r_ext;
        logic [CMP_W-1:0]    d_sh;
        logic [CMP_W-1:0]    r_dif;
        logic                ge;
        logic [NUM_W-1:0]    r_next;
        logic [F:0]          q_next;

        if (k == 0) begin : g_head
            assign c_in = ctl_in;
            assign r_in = num_in;
            assign d_in = den_in;
            assign q_in = '0;
        end
        else begin : g_body
            assign c_in = ctl_reg[k-1];
            assign r_in = r_reg[k-1];
            assign d_in = d_reg[k-1];
            assign q_in = q_reg[k-1];
        end

        // trial subtract of the shifted divisor
        assign r_ext  = CMP_W'(r_in);
        assign d_sh   = CMP_W'(d_in) << SH;
        assign ge     = (r_ext >= d_sh);
        assign r_dif  = r_ext - d_sh;
        assign r_next = ge ? r_dif[NUM_W-1:0] : r_in;

        always_comb
        begin
            q_next     = q_in;
            q_next[SH] = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k].valid <= 1'b0;
            end
            else
            begin
                ctl_reg[k] <= c_in;
            end
        end

        always_ff @(posedge clk)
        begin
            r_reg[k] <= r_next;
            d_reg[k] <= d_in;
            q_reg[k] <= q_next;
        end
    end

    assign ctl_out = ctl_reg[F];
    assign quo_out = q_reg[F];

`ifndef SYNTH
    // a normal beat leaves a remainder below the divisor
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_out.valid && (ctl_out.stat == hhsa_pkg::STAT_NORMAL)
        |-> (r_reg[F] < d_reg[F]))
        else $error("hhsa_div: remainder not below divisor");

    // the range check ahead of the divider keeps a normal quotient within one
    a_quo_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_out.valid && (ctl_out.stat == hhsa_pkg::STAT_NORMAL)
        |-> (quo_out <= ONE_Q))
        else $error("hhsa_div: quotient above one on a normal beat");
`endif

endmodule
